// ===== sv/quoted_argument_tokenizer_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the quoted argument tokenizer
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef QUOTED_ARGUMENT_TOKENIZER_TOP_DEFINES_SVH
`define QUOTED_ARGUMENT_TOKENIZER_TOP_DEFINES_SVH

// plain property check
`define QAT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define QAT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QAT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/qat_pkg.sv =====
// ---------------------------------------------------------------------------
// qat_pkg
// Types, parse mode codes and character constants for the tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package qat_pkg;

	localparam int MAX_RES = 3;

	// parse modes
	localparam logic [2:0] MODE_SPACES  = 3'd0;
	localparam logic [2:0] MODE_ARG     = 3'd1;
	localparam logic [2:0] MODE_SQUOTE  = 3'd2;
	localparam logic [2:0] MODE_DQUOTE  = 3'd3;
	localparam logic [2:0] MODE_ESC_OUT = 3'd4;
	localparam logic [2:0] MODE_ESC_DQ  = 3'd5;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	typedef struct packed {
		logic [7:0] ch;
		logic       byte_vld;
		logic       closed;
		logic       fin;
		logic       ok;
	} result_t;

	// everything one request produces
	typedef struct packed {
		result_t [MAX_RES-1:0] res;
		logic [1:0]            cnt;
		logic [2:0]            next_mode;
	} dec_t;

	function automatic result_t mk_byte(input logic [7:0] c);
		result_t r;
		r = '0;
		r.ch = c;
		r.byte_vld = 1'b1;
		return r;
	endfunction

	function automatic result_t mk_close();
		result_t r;
		r = '0;
		r.closed = 1'b1;
		return r;
	endfunction

	function automatic result_t mk_final(input logic good);
		result_t r;
		r = '0;
		r.fin = 1'b1;
		r.ok = good;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/qat_decode.sv =====
// ---------------------------------------------------------------------------
// qat_decode
// Per-request decode: result list, result count and next parse mode.
// ---------------------------------------------------------------------------
`default_nettype none

module qat_decode (
	input  wire logic [2:0] mode,
	input  wire logic [7:0] ch,
	input  wire logic       present,
	input  wire logic       eol,
	output qat_pkg::dec_t   dec
);
	import qat_pkg::*;

	logic [2:0]            m;
	logic [1:0]            k;
	result_t [MAX_RES-1:0] res;

	always_comb begin
		// unused codes behave as eating spaces
		m = (mode > MODE_ESC_DQ) ? MODE_SPACES : mode;
		res = '0;
		k = 2'd0;

		if (present) begin
			unique case (m)
				MODE_SQUOTE: begin
					if (ch == CH_SQ) begin
						m = MODE_ARG;
					end else begin
						res[k] = mk_byte(ch);
						k = k + 2'd1;
					end
				end
				MODE_DQUOTE: begin
					if (ch == CH_DQ) begin
						m = MODE_ARG;
					end else if (ch == CH_BSL) begin
						m = MODE_ESC_DQ;
					end else begin
						res[k] = mk_byte(ch);
						k = k + 2'd1;
					end
				end
				MODE_ESC_OUT: begin
					res[k] = mk_byte(ch);
					k = k + 2'd1;
					m = MODE_ARG;
				end
				MODE_ESC_DQ: begin
					// backslash kept unless it escapes a quote or backslash
					if (ch != CH_DQ && ch != CH_BSL) begin
						res[k] = mk_byte(CH_BSL);
						k = k + 2'd1;
					end
					res[k] = mk_byte(ch);
					k = k + 2'd1;
					m = MODE_DQUOTE;
				end
				default: begin
					if (ch == CH_DQ) begin
						m = MODE_DQUOTE;
					end else if (ch == CH_SQ) begin
						m = MODE_SQUOTE;
					end else if (ch == CH_BSL) begin
						m = MODE_ESC_OUT;
					end else if (ch == CH_SPACE || ch == CH_NL || ch == CH_TAB) begin
						if (m == MODE_ARG) begin
							res[k] = mk_close();
							k = k + 2'd1;
						end
						m = MODE_SPACES;
					end else begin
						res[k] = mk_byte(ch);
						k = k + 2'd1;
						m = MODE_ARG;
					end
				end
			endcase
		end

		if (eol) begin
			if (m == MODE_ARG) begin
				res[k] = mk_close();
				k = k + 2'd1;
				res[k] = mk_final(1'b1);
				k = k + 2'd1;
			end else begin
				// open quote or dangling escape fails the line
				res[k] = mk_final(m == MODE_SPACES);
				k = k + 2'd1;
			end
			m = MODE_SPACES;
		end

		dec.res = res;
		dec.cnt = k;
		dec.next_mode = m;
	end

endmodule

`default_nettype wire

// ===== sv/quoted_argument_tokenizer_top.sv =====
// ---------------------------------------------------------------------------
// quoted_argument_tokenizer_top
// Shell-style argument tokenizer with quotes and escapes, one byte a request.
// ---------------------------------------------------------------------------
// Pipeline: input register, then result register.
// Throughput: one request per cycle while each yields at most one result
//   and out_ready is high; a request with N results (N <= 3) holds the
//   result register until all N are accepted.
// Reset: arst_n clears the valid flags and returns the parse mode to
//   eating spaces; payload registers are not reset.
`default_nettype none

module quoted_argument_tokenizer_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// request channel
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] byte_value,
	input  wire logic       byte_present,
	input  wire logic       line_end,
	// result channel
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            out_byte_valid,
	output logic            argument_closed,
	output logic            line_finished,
	output logic            line_ok,
	output logic            last_of_run
);
	import qat_pkg::*;
`include "quoted_argument_tokenizer_top_defines.svh"

	// stage 1: registered request
	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       present_s1;
	logic       eol_s1;

	// parse state, advanced when a request leaves stage 1
	logic [2:0] mode_q;

	// stage 2: result list of one request, drained one per cycle while out_ready is high
	logic                  vld_s2;
	result_t [MAX_RES-1:0] res_s2;
	logic [1:0]            cnt_s2;
	logic [1:0]            idx_q;

	dec_t    dec;
	result_t cur;
	logic    last;
	logic    s2_free;
	logic    s1_go;

	qat_decode u_decode (
		.mode    (mode_q),
		.ch      (ch_s1),
		.present (present_s1),
		.eol     (eol_s1),
		.dec     (dec)
	);

	// last result of the run currently on the output
	assign last    = (idx_q == (cnt_s2 - 2'd1));
	assign s2_free = !vld_s2 || (out_ready && last);
	// requests with no result pass straight through without a stage 2 slot
	assign s1_go    = vld_s1 && ((dec.cnt == 2'd0) || s2_free);
	assign in_ready = !vld_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1      <= byte_value;
			present_s1 <= byte_present;
			eol_s1     <= line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SPACES;
		end else if (s1_go) begin
			mode_q <= dec.next_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			idx_q  <= 2'd0;
		end else if (s1_go && (dec.cnt != 2'd0)) begin
			vld_s2 <= 1'b1;
			idx_q  <= 2'd0;
		end else if (vld_s2 && out_ready) begin
			if (last) begin
				vld_s2 <= 1'b0;
				idx_q  <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && (dec.cnt != 2'd0)) begin
			res_s2 <= dec.res;
			cnt_s2 <= dec.cnt;
		end
	end

	assign cur             = res_s2[idx_q];
	assign out_valid       = vld_s2;
	assign out_byte        = cur.ch;
	assign out_byte_valid  = cur.byte_vld;
	assign argument_closed = cur.closed;
	assign line_finished   = cur.fin;
	assign line_ok         = cur.ok;
	assign last_of_run     = last;

	// checks
	`QAT_ASSERT_IMP(a_cnt_nonzero, vld_s2, cnt_s2 != 2'd0, "empty run held in stage 2")
	`QAT_ASSERT_IMP(a_idx_in_run, vld_s2, idx_q < cnt_s2, "result index past end of run")
	`QAT_ASSERT_IMP(a_one_kind, vld_s2,
		$onehot({out_byte_valid, argument_closed, line_finished}), "result kind not unique")
	`QAT_ASSERT_NXT(a_line_resets_mode, s1_go && eol_s1, mode_q == MODE_SPACES,
		"parse mode not reset after line end")
	`QAT_ASSERT_IMP(a_stall_has_item, !in_ready, vld_s1, "stalled with empty input stage")

endmodule

`default_nettype wire

// ===== verif/qat_tb_pkg.sv =====
// ---------------------------------------------------------------------------
// qat_tb_pkg
// Expected-token ledger for the tokenizer bench: tracks the parse mode per
// accepted request and holds the results still owed by the block.
// ---------------------------------------------------------------------------
package qat_tb_pkg;

	import qat_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_byte;
		logic       closed;
		logic       fin;
		logic       ok;
		logic       last;
	} token_t;

	class token_ledger;
		logic [2:0] lex_mode;
		token_t     owed_tokens[$];
		int         mismatches;

		function new();
			lex_mode = MODE_SPACES;
			mismatches = 0;
		endfunction

		function int owed_count();
			return owed_tokens.size();
		endfunction

		function void owe(logic [7:0] c, logic is_byte, logic closed, logic fin, logic ok);
			token_t t;
			t = '{c, is_byte, closed, fin, ok, 1'b0};
			owed_tokens = {owed_tokens, t};
		endfunction

		// one request in, its results appended to the owed list
		function void note_request(logic [7:0] c, logic present, logic eol);
			int first;
			first = owed_tokens.size();
			if (lex_mode > MODE_ESC_DQ)
				lex_mode = MODE_SPACES;
			if (present) begin
				case (lex_mode)
					MODE_SQUOTE: begin
						if (c == CH_SQ)
							lex_mode = MODE_ARG;
						else
							owe(c, 1'b1, 1'b0, 1'b0, 1'b0);
					end
					MODE_DQUOTE: begin
						if (c == CH_DQ)
							lex_mode = MODE_ARG;
						else if (c == CH_BSL)
							lex_mode = MODE_ESC_DQ;
						else
							owe(c, 1'b1, 1'b0, 1'b0, 1'b0);
					end
					MODE_ESC_OUT: begin
						owe(c, 1'b1, 1'b0, 1'b0, 1'b0);
						lex_mode = MODE_ARG;
					end
					MODE_ESC_DQ: begin
						// backslash survives unless it escaped a quote or backslash
						if (c != CH_DQ && c != CH_BSL)
							owe(CH_BSL, 1'b1, 1'b0, 1'b0, 1'b0);
						owe(c, 1'b1, 1'b0, 1'b0, 1'b0);
						lex_mode = MODE_DQUOTE;
					end
					default: begin
						if (c == CH_DQ)
							lex_mode = MODE_DQUOTE;
						else if (c == CH_SQ)
							lex_mode = MODE_SQUOTE;
						else if (c == CH_BSL)
							lex_mode = MODE_ESC_OUT;
						else if (c == CH_SPACE || c == CH_NL || c == CH_TAB) begin
							if (lex_mode == MODE_ARG)
								owe(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
							lex_mode = MODE_SPACES;
						end else begin
							owe(c, 1'b1, 1'b0, 1'b0, 1'b0);
							lex_mode = MODE_ARG;
						end
					end
				endcase
			end
			if (eol) begin
				if (lex_mode == MODE_ARG) begin
					owe(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
					owe(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
				end else if (lex_mode == MODE_SPACES)
					owe(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
				else
					owe(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
				lex_mode = MODE_SPACES;
			end
			if (owed_tokens.size() > first)
				owed_tokens[owed_tokens.size() - 1].last = 1'b1;
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				mismatches++;
			end
		endfunction

		function void compare_flag(string field, logic want, logic got);
			if (got !== want) begin
				$error("%s: expected %0b, got %0b", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(logic [7:0] b, logic bv, logic cl, logic fin, logic ok,
				logic last);
			token_t want;
			if (owed_tokens.size() == 0) begin
				$error("result with nothing owed: out_byte %0h valid %0b closed %0b fin %0b",
					b, bv, cl, fin);
				mismatches++;
				return;
			end
			want = owed_tokens.pop_front();
			compare_field("out_byte", want.ch, b);
			compare_flag("out_byte_valid", want.is_byte, bv);
			compare_flag("argument_closed", want.closed, cl);
			compare_flag("line_finished", want.fin, fin);
			compare_flag("line_ok", want.ok, ok);
			compare_flag("last_of_run", want.last, last);
		endfunction
	endclass

endpackage

// ===== verif/quoted_argument_tokenizer_top_tb.sv =====
// ---------------------------------------------------------------------------
// quoted_argument_tokenizer_top_tb
// Drives command-line bytes into the tokenizer: a directed run over quoting,
// escapes, separators and line ends, then random lines (mostly well formed,
// some broken or pure noise). Every result is checked against a ledger that
// tracks the parse mode on its own. Both sides stall at random, and the
// receiver holds off once long enough to back the block up.
// ---------------------------------------------------------------------------
module quoted_argument_tokenizer_top_tb;

	import qat_pkg::*;
	import qat_tb_pkg::*;

	localparam int ITEM_TARGET     = 450;
	localparam int CALM_FROM       = 400;  // no idling past this many requests
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int STALL_LIMIT     = 1000; // cycles with no handshake at all
	localparam int DRAIN_CYCLES    = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic       present;
		logic       eol;
	} line_item_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] byte_value;
	logic       byte_present;
	logic       line_end;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       out_byte_valid;
	logic       argument_closed;
	logic       line_finished;
	logic       line_ok;
	logic       last_of_run;

	token_ledger ledger = new();
	line_item_t  line_buf[$];
	int          items_sent = 0;
	bit          calm = 1'b0;
	bit          hold_off_request = 1'b0;

	quoted_argument_tokenizer_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.byte_value     (byte_value),
		.byte_present   (byte_present),
		.line_end       (line_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.out_byte_valid (out_byte_valid),
		.argument_closed(argument_closed),
		.line_finished  (line_finished),
		.line_ok        (line_ok),
		.last_of_run    (last_of_run)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Offer one request and hold it until the block takes it. Called at a
	// rising edge; leaves valid high when the next request follows directly,
	// so valid never drops and rises within the same step.
	task automatic send_request(input logic [7:0] c, input logic present, input logic eol);
		in_valid     <= 1'b1;
		byte_value   <= c;
		byte_present <= present;
		line_end     <= eol;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		ledger.note_request(c, present, eol);
		items_sent++;
		if (items_sent >= CALM_FROM)
			calm = 1'b1;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Random byte, weighted toward the characters the parser reacts to.
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0: return CH_SPACE;
			1: return CH_DQ;
			2: return CH_SQ;
			3: return CH_BSL;
			4: return ($urandom_range(0, 1) != 0) ? CH_NL : CH_TAB;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 2))
			0: return CH_SPACE;
			1: return CH_NL;
			default: return CH_TAB;
		endcase
	endfunction

	function automatic void push_item(logic [7:0] c, logic present, logic eol);
		line_item_t it;
		it = '{c, present, eol};
		line_buf = {line_buf, it};
	endfunction

	// Build one command line in line_buf. Most lines are sequences of
	// words, quoted strings, escapes and separators; some end inside a
	// quote or escape, and some are raw noise.
	function automatic void compose_line();
		logic [7:0] c;
		int         tokens;
		line_buf.delete();
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 8))
				push_item(pick_char(), $urandom_range(0, 7) != 0, $urandom_range(0, 5) == 0);
			return;
		end
		tokens = $urandom_range(1, 5);
		repeat (tokens) begin
			if ($urandom_range(0, 2) != 0)
				repeat ($urandom_range(1, 2)) push_item(pick_space(), 1'b1, 1'b0);
			case ($urandom_range(0, 4))
				0: begin
					// plain word
					repeat ($urandom_range(1, 4)) begin
						do
							c = 8'($urandom_range(0, 255));
						while (c == CH_SPACE || c == CH_NL || c == CH_TAB || c == CH_DQ ||
							c == CH_SQ || c == CH_BSL);
						push_item(c, 1'b1, 1'b0);
					end
				end
				1: begin
					// single-quoted, possibly empty
					push_item(CH_SQ, 1'b1, 1'b0);
					repeat ($urandom_range(0, 3)) begin
						do
							c = pick_char();
						while (c == CH_SQ);
						push_item(c, 1'b1, 1'b0);
					end
					push_item(CH_SQ, 1'b1, 1'b0);
				end
				2: begin
					// double-quoted with escapes, possibly empty
					push_item(CH_DQ, 1'b1, 1'b0);
					repeat ($urandom_range(0, 3)) begin
						if ($urandom_range(0, 2) == 0) begin
							push_item(CH_BSL, 1'b1, 1'b0);
							push_item(pick_char(), 1'b1, 1'b0);
						end else begin
							do
								c = pick_char();
							while (c == CH_DQ || c == CH_BSL);
							push_item(c, 1'b1, 1'b0);
						end
					end
					push_item(CH_DQ, 1'b1, 1'b0);
				end
				3: begin
					push_item(CH_BSL, 1'b1, 1'b0);
					push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
				end
				default: push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			endcase
		end
		// now and then leave the line unbalanced
		case ($urandom_range(0, 9))
			0: push_item(CH_SQ, 1'b1, 1'b0);
			1: push_item(CH_DQ, 1'b1, 1'b0);
			2: push_item(CH_BSL, 1'b1, 1'b0);
			default: ;
		endcase
		if ($urandom_range(0, 1) != 0)
			line_buf[line_buf.size() - 1].eol = 1'b1;
		else
			push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endfunction

	// Stimulus and end of run.
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		byte_value   = 8'h00;
		byte_present = 1'b0;
		line_end     = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes, tab close, eaten space run
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'hFF, 1'b1, 1'b0);
		send_request(CH_TAB, 1'b1, 1'b0);
		send_request(CH_SPACE, 1'b1, 1'b0);
		// empty single-quoted argument, closed by newline
		send_request(CH_SQ, 1'b1, 1'b0);
		send_request(CH_SQ, 1'b1, 1'b0);
		send_request(CH_NL, 1'b1, 1'b0);
		// double quotes: escaped quote, escaped backslash, kept backslash
		send_request(CH_DQ, 1'b1, 1'b0);
		send_request(CH_BSL, 1'b1, 1'b0);
		send_request(CH_DQ, 1'b1, 1'b0);
		send_request(CH_BSL, 1'b1, 1'b0);
		send_request(CH_BSL, 1'b1, 1'b0);
		send_request(CH_BSL, 1'b1, 1'b0);
		send_request("q", 1'b1, 1'b0);
		send_request(CH_DQ, 1'b1, 1'b0);
		// bare marker alone, then bare end marker inside an argument
		send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		// escaped space outside quotes, then line ends in a single quote
		send_request(CH_BSL, 1'b1, 1'b0);
		send_request(CH_SPACE, 1'b1, 1'b0);
		send_request(CH_SQ, 1'b1, 1'b0);
		send_request("z", 1'b1, 1'b1);
		// unbalanced: open double quote, trailing escape, escape inside quotes
		send_request(CH_DQ, 1'b1, 1'b1);
		send_request(CH_BSL, 1'b1, 1'b1);
		send_request(CH_DQ, 1'b1, 1'b0);
		send_request(CH_BSL, 1'b1, 1'b1);
		// byte, close and final from one request
		send_request("A", 1'b1, 1'b1);

		// long receiver hold-off while random lines keep coming
		hold_off_request = 1'b1;
		while (items_sent < ITEM_TARGET) begin
			compose_line();
			foreach (line_buf[i])
				send_request(line_buf[i].ch, line_buf[i].present, line_buf[i].eol);
		end
		in_valid <= 1'b0;

		// the watchdog bounds this wait
		while (ledger.owed_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (ledger.mismatches == 0 && ledger.owed_count() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Result side: check on each accepted result, then pick next ready.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready)
				ledger.check_result(out_byte, out_byte_valid, argument_closed,
					line_finished, line_ok, last_of_run);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (hold_off_request) begin
				hold_off_request = 1'b0;
				stall_left = HOLD_OFF_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	// Watchdog: give up after too long with no handshake on either side.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

endmodule
